FILE: rtl/core/spq_pkg.sv
`default_nettype none

package spq_pkg;

    localparam int DATA_W = 8;
    localparam int PRIO_W = 3;
    localparam int OCC_W  = 7;

    localparam logic CMD_ENQ = 1'b0;
    localparam logic CMD_DEQ = 1'b1;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    // contents of one cell as seen by its neighbors
    typedef struct packed {
        logic              valid;
        logic [PRIO_W-1:0] prio;
        logic [DATA_W-1:0] data;
    } entry_t;

    // operation broadcast to every cell in the chain
    typedef struct packed {
        logic              enq;
        logic              deq;
        logic [PRIO_W-1:0] prio;
        logic [DATA_W-1:0] data;
    } cell_cmd_t;

endpackage

`default_nettype wire

FILE: rtl/core/spq_if.sv
`default_nettype none

interface spq_req_if
    import spq_pkg::*;
;
    logic              valid;
    logic              ready;
    logic              command;
    logic [DATA_W-1:0] item_data;
    logic [PRIO_W-1:0] item_priority;

    modport source (output valid, output command, output item_data,
                    output item_priority, input ready);
    modport sink   (input valid, input command, input item_data,
                    input item_priority, output ready);
endinterface

interface spq_rsp_if
    import spq_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] out_data;
    logic              out_valid;
    status_t           status;
    logic [OCC_W-1:0]  occupancy;

    modport source (output valid, output out_data, output out_valid,
                    output status, output occupancy, input ready);
    modport sink   (input valid, input out_data, input out_valid,
                    input status, input occupancy, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/spq_cell.sv
`default_nettype none

module spq_cell
    import spq_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire cell_cmd_t cmd,
    input  wire entry_t    left,
    input  wire entry_t    right,
    output entry_t         cur
);

    logic              valid_reg;
    logic              valid_next;
    logic [PRIO_W-1:0] prio_reg;
    logic [PRIO_W-1:0] prio_next;
    logic [DATA_W-1:0] data_reg;
    logic [DATA_W-1:0] data_next;

    logic left_disp;
    logic take_new;

    // left neighbor is pushed back by the new entry
    assign left_disp = left.valid && (left.prio < cmd.prio);
    // new entry lands here: left stays, this slot is free or lower
    assign take_new  = left.valid && (left.prio >= cmd.prio)
                       && (!valid_reg || (prio_reg < cmd.prio));

    always_comb
    begin
        valid_next = valid_reg;
        prio_next  = prio_reg;
        data_next  = data_reg;
        if (cmd.deq)
        begin
            valid_next = right.valid;
            prio_next  = right.prio;
            data_next  = right.data;
        end
        else if (cmd.enq)
        begin
            if (left_disp)
            begin
                valid_next = 1'b1;
                prio_next  = left.prio;
                data_next  = left.data;
            end
            else if (take_new)
            begin
                valid_next = 1'b1;
                prio_next  = cmd.prio;
                data_next  = cmd.data;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prio_reg <= prio_next;
        data_reg <= data_next;
    end

    assign cur = '{valid: valid_reg, prio: prio_reg, data: data_reg};

endmodule

`default_nettype wire

FILE: rtl/core/stable_priority_queue.sv
// Channel | Dir | Fields                                       | Beat accepted
// req     | in  | command, item_data, item_priority            | valid && ready
// rsp     | out | out_data, out_valid, status, occupancy       | valid && ready
//
// One beat per cycle while rsp.ready is high: each cell compares and shifts in the same edge that
// accepts the beat, and the result register loads on that edge too, so the
// result is offered from the next cycle.
// req.ready is high while the result register is empty or being drained.
// Reset clears all cell valid bits, the count and the result valid flag.
`default_nettype none

module stable_priority_queue
    import spq_pkg::*;
#(
    parameter int CAPACITY        = 64,
    parameter int PRIORITY_LEVELS = 8
)
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    spq_req_if.sink    req,
    spq_rsp_if.source  rsp
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    entry_t            cells [CAPACITY];
    entry_t            lefts [CAPACITY];
    entry_t            rights [CAPACITY];
    cell_cmd_t         cmd;

    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;

    logic              rsp_vld_reg;
    logic [DATA_W-1:0] rsp_data_reg;
    logic [DATA_W-1:0] rsp_data_next;
    logic              rsp_ok_reg;
    logic              rsp_ok_next;
    status_t           rsp_st_reg;
    status_t           rsp_st_next;
    logic [OCC_W-1:0]  rsp_occ_reg;

    logic              acc;
    logic              full;
    logic              empty;
    logic [PRIO_W-1:0] prio_sat;

    assign req.ready = !rsp_vld_reg || rsp.ready;
    assign acc       = req.valid && req.ready;
    assign full      = cells[CAPACITY-1].valid;
    assign empty     = !cells[0].valid;

    assign prio_sat = (32'(req.item_priority) >= PRIORITY_LEVELS)
                      ? PRIO_W'(PRIORITY_LEVELS - 1) : req.item_priority;

    assign cmd.enq  = acc && (req.command == CMD_ENQ) && !full;
    assign cmd.deq  = acc && (req.command == CMD_DEQ) && !empty;
    assign cmd.prio = prio_sat;
    assign cmd.data = req.item_data;

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_chain
            if (gi == 0)
            begin : g_head
                assign lefts[gi] = '{valid: 1'b1, prio: '1, data: '0};
            end
            else
            begin : g_body
                assign lefts[gi] = cells[gi-1];
            end

            if (gi == CAPACITY - 1)
            begin : g_tail
                assign rights[gi] = '{valid: 1'b0, prio: '0, data: '0};
            end
            else
            begin : g_next
                assign rights[gi] = cells[gi+1];
            end

            spq_cell u_cell (
                .clk   (clk),
                .rst_n (rst_n),
                .cmd   (cmd),
                .left  (lefts[gi]),
                .right (rights[gi]),
                .cur   (cells[gi])
            );
        end
    endgenerate

    always_comb
    begin
        count_next    = count_reg;
        rsp_data_next = '0;
        rsp_ok_next   = 1'b0;
        rsp_st_next   = ST_DONE;
        if (req.command == CMD_ENQ)
        begin
            if (full)
            begin
                rsp_st_next = ST_FULL;
            end
            else
            begin
                count_next = count_reg + 1'b1;
            end
        end
        else
        begin
            if (empty)
            begin
                rsp_st_next = ST_EMPTY;
            end
            else
            begin
                count_next    = count_reg - 1'b1;
                rsp_data_next = cells[0].data;
                rsp_ok_next   = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            rsp_vld_reg <= 1'b0;
        end
        else
        begin
            if (acc)
            begin
                count_reg   <= count_next;
                rsp_vld_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            rsp_data_reg <= rsp_data_next;
            rsp_ok_reg   <= rsp_ok_next;
            rsp_st_reg   <= rsp_st_next;
            rsp_occ_reg  <= OCC_W'(count_next);
        end
    end

    assign rsp.valid     = rsp_vld_reg;
    assign rsp.out_data  = rsp_data_reg;
    assign rsp.out_valid = rsp_ok_reg;
    assign rsp.status    = rsp_st_reg;
    assign rsp.occupancy = rsp_occ_reg;

endmodule

`default_nettype wire
